// ===== rtl/nskt_pkg.sv =====
// Shared types and constants for the norm-sorted keyed table.
package nskt_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int FIELD_W     = 16;
  localparam int NORM_W      = 2 * FIELD_W;
  localparam int COUNT_OUT_W = 5;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_LIST     = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK   = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } status_t;

  // id sits in the low bits so the record maps straight onto tdata
  typedef struct packed {
    logic        [FIELD_W-1:0] tag;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] id;
  } entry_t;

  typedef struct packed {
    status_t                  status;
    logic                     entry_valid;
    entry_t                   entry;
    logic [COUNT_OUT_W-1:0]   count;
    logic                     last;
  } result_t;

  typedef struct packed {
    logic en;
    logic clear;
  } sq_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NX,
    S_NY,
    S_SRD,
    S_SX,
    S_SY,
    S_SCMP,
    S_DEC,
    S_ARD,
    S_AWR,
    S_INS,
    S_RRD,
    S_RWR,
    S_REPLY,
    S_LRD,
    S_LEMIT
  } state_t;

endpackage

// ===== rtl/nskt_sqacc.sv =====
// Shared square-and-accumulate unit: one signed square per enabled cycle into a norm register.
module nskt_sqacc (
  input  logic                                clk,
  input  nskt_pkg::sq_ctl_t                   ctl,
  input  logic signed [nskt_pkg::FIELD_W-1:0] op,
  output logic        [nskt_pkg::NORM_W-1:0]  acc
);
  import nskt_pkg::*;

  logic signed [NORM_W-1:0] sq;
  logic        [NORM_W-1:0] base;

  assign sq   = NORM_W'(op) * NORM_W'(op);
  assign base = ctl.clear ? '0 : acc;

  // two squares of at most 2^30 each never overflow the norm width
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= base + NORM_W'(unsigned'(sq));
    end
  end

endmodule

// ===== rtl/nskt_ctrl.sv =====
// Sequencer and entry store: scan, shift insert, shift remove and list walk.
module nskt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  nskt_pkg::cmd_t     in_cmd,
  input  nskt_pkg::entry_t   in_entry,
  input  logic               out_free,
  output logic               res_load,
  output nskt_pkg::result_t  res
);
  import nskt_pkg::*;

  state_t state, state_next;

  entry_t mem [CAPACITY];
  entry_t rd_data;
  entry_t wr_data;
  logic   [IDX_W-1:0] rd_addr;
  logic   [IDX_W-1:0] wr_addr;
  logic               we;

  cmd_t               cmd;
  entry_t             key;
  status_t            sts;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   ptr;
  logic [IDX_W-1:0]   hit;
  logic [IDX_W-1:0]   at;
  logic               found;
  logic               pos_found;
  logic [NORM_W-1:0]  new_norm;

  sq_ctl_t                   sq_ctl;
  logic signed [FIELD_W-1:0] sq_op;
  logic [NORM_W-1:0]         acc;

  logic [CNT_W-1:0]   ptr_ext;
  logic [IDX_W-1:0]   ins;
  logic               list_last;

  nskt_sqacc u_sqacc (
    .clk (clk),
    .ctl (sq_ctl),
    .op  (sq_op),
    .acc (acc)
  );

  assign ptr_ext   = CNT_W'(ptr);
  assign ins       = pos_found ? at : IDX_W'(count);
  assign list_last = (ptr_ext + CNT_W'(1) == count) ||
                     (32'(ptr) + 32'd1 == 32'(MAX_RESULTS));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    rd_addr          = ptr;
    we               = 1'b0;
    wr_addr          = ptr;
    wr_data          = rd_data;
    sq_op            = rd_data.x;
    sq_ctl           = '0;
    res_load         = 1'b0;
    res.status       = sts;
    res.entry_valid  = 1'b0;
    res.entry        = '0;
    res.count        = COUNT_OUT_W'(count);
    res.last         = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_cmd)
            CMD_ADD:  state_next = S_NX;
            CMD_LIST: state_next = (count == '0) ? S_REPLY : S_LRD;
            default:  state_next = (count == '0) ? S_REPLY : S_SRD;
          endcase
        end
      end
      S_NX: begin
        sq_op      = key.x;
        sq_ctl     = '{en: 1'b1, clear: 1'b1};
        state_next = S_NY;
      end
      S_NY: begin
        sq_op      = key.y;
        sq_ctl     = '{en: 1'b1, clear: 1'b0};
        state_next = (count == '0) ? S_DEC : S_SRD;
      end
      S_SRD: state_next = S_SX;
      S_SX: begin
        sq_op      = rd_data.x;
        sq_ctl     = '{en: 1'b1, clear: 1'b1};
        state_next = S_SY;
      end
      S_SY: begin
        sq_op      = rd_data.y;
        sq_ctl     = '{en: 1'b1, clear: 1'b0};
        state_next = S_SCMP;
      end
      S_SCMP: state_next = (ptr_ext + CNT_W'(1) == count) ? S_DEC : S_SRD;
      S_DEC: begin
        unique case (cmd)
          CMD_ADD: begin
            if (found || count >= CNT_W'(CAPACITY)) begin
              state_next = S_REPLY;
            end else if (CNT_W'(ins) == count) begin
              state_next = S_INS;
            end else begin
              state_next = S_ARD;
            end
          end
          CMD_REMOVE: begin
            if (!found || CNT_W'(hit) + CNT_W'(1) == count) begin
              state_next = S_REPLY;
            end else begin
              state_next = S_RRD;
            end
          end
          default: state_next = S_REPLY;
        endcase
      end
      S_ARD: begin
        rd_addr    = ptr - IDX_W'(1);
        state_next = S_AWR;
      end
      S_AWR: begin
        we         = 1'b1;
        wr_addr    = ptr;
        wr_data    = rd_data;
        state_next = (ptr - IDX_W'(1) == at) ? S_INS : S_ARD;
      end
      S_INS: begin
        we         = 1'b1;
        wr_addr    = at;
        wr_data    = key;
        state_next = S_REPLY;
      end
      S_RRD: begin
        rd_addr    = ptr + IDX_W'(1);
        state_next = S_RWR;
      end
      S_RWR: begin
        we         = 1'b1;
        wr_addr    = ptr;
        wr_data    = rd_data;
        // count already holds the reduced value here
        state_next = (ptr_ext + CNT_W'(1) == count) ? S_REPLY : S_RRD;
      end
      S_REPLY: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LRD: state_next = S_LEMIT;
      S_LEMIT: begin
        if (out_free) begin
          res_load        = 1'b1;
          res.status      = STS_OK;
          res.entry_valid = 1'b1;
          res.entry       = rd_data;
          res.last        = list_last;
          state_next      = list_last ? S_IDLE : S_LRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      found     <= 1'b0;
      pos_found <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd       <= in_cmd;
            key       <= in_entry;
            ptr       <= '0;
            found     <= 1'b0;
            pos_found <= 1'b0;
            sts       <= (in_cmd == CMD_ADD || in_cmd == CMD_LIST) ? STS_OK : STS_MISS;
          end
        end
        S_SRD: begin
          // the accumulator still holds the new item's norm before the first entry
          if (cmd == CMD_ADD && ptr == '0) begin
            new_norm <= acc;
          end
        end
        S_SCMP: begin
          if (!found && rd_data.id == key.id) begin
            found <= 1'b1;
            hit   <= ptr;
          end
          // first stored entry not below the new norm: ties land newest first
          if (cmd == CMD_ADD && !pos_found && acc >= new_norm) begin
            pos_found <= 1'b1;
            at        <= ptr;
          end
          ptr <= ptr + IDX_W'(1);
        end
        S_DEC: begin
          unique case (cmd)
            CMD_ADD: begin
              if (found) begin
                sts <= STS_MISS;
              end else if (count >= CNT_W'(CAPACITY)) begin
                sts <= STS_FULL;
              end else begin
                sts <= STS_OK;
              end
              at  <= ins;
              ptr <= IDX_W'(count);
            end
            CMD_REMOVE: begin
              sts <= found ? STS_OK : STS_MISS;
              ptr <= hit;
              if (found) begin
                count <= count - CNT_W'(1);
              end
            end
            default: sts <= found ? STS_OK : STS_MISS;
          endcase
        end
        S_AWR:   ptr   <= ptr - IDX_W'(1);
        S_INS:   count <= count + CNT_W'(1);
        S_RWR:   ptr   <= ptr + IDX_W'(1);
        S_LEMIT: begin
          if (out_free && !list_last) begin
            ptr <= ptr + IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (32'(count) == 32'($past(count)) + 32'd1 ||
       32'(count) + 32'd1 == 32'($past(count))))
    else $error("entry count moved by more than one");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS) |-> (32'(count) < 32'(CAPACITY)))
    else $error("insert into a full table");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result loaded over a pending transfer");

  a_list_order: assert property (@(posedge clk) disable iff (rst)
    (res_load && res.entry_valid && !res.last) |=> (state == S_LRD))
    else $error("list walk lost its place");

endmodule

// ===== rtl/norm_sorted_keyed_table.sv =====
// Norm-sorted keyed table: stream front end, output register and command sequencer.
//
// Holds up to CAPACITY entries (id, x, y, tag) sorted by x*x+y*y, equal norms
// newest first. One command is taken at a time; s_tready is low until its last
// result transfer has been loaded. Every entry is visited through one memory
// read port and one squarer. With n entries held, add scans every held entry and
// then shifts entries up, remove scans them all and then shifts entries down,
// contains scans them all, and list emits one result transfer per entry read;
// output backpressure stalls all of these. No clearing pass after reset is
// needed.
module norm_sorted_keyed_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // key_id, coord_x, coord_y, name_tag
  input  logic [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // out_id, out_x, out_y, out_tag, entry_count, zero pad
  output logic [2:0]  m_tuser,   // status, entry_valid
  output logic        m_tlast
);
  import nskt_pkg::*;

  logic    in_ready;
  logic    out_free;
  logic    res_load;
  result_t res;
  result_t out_reg;

  assign s_tready = in_ready;
  assign out_free = !m_tvalid || m_tready;

  nskt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (in_ready),
    .in_cmd   (cmd_t'(s_tuser)),
    .in_entry (entry_t'(s_tdata)),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_reg <= res;
    end
  end

  assign m_tdata = {3'b000, out_reg.count, out_reg.entry};
  assign m_tuser = {out_reg.entry_valid, STATUS_W'(out_reg.status)};
  assign m_tlast = out_reg.last;

endmodule

// ===== tb/tb_norm_sorted_keyed_table.sv =====
// Self-checking testbench for norm_sorted_keyed_table: table commands in, checked replies out.
module tb_norm_sorted_keyed_table;
  import nskt_pkg::*;

  localparam int LONG_HOLD   = 400;
  localparam int RANDOM_CMDS = 500;
  localparam int TAIL_CYCLES = 150;

  typedef struct {
    cmd_t        cmd;
    logic [15:0] id;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] tag;
    bit          drain;  // hold this command until every reply is back
    bit          gappy;  // random sender gap after this command
  } table_cmd_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // key_id, coord_x, coord_y, name_tag
  logic [1:0]  s_tuser = '0;   // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // out_id, out_x, out_y, out_tag, entry_count, zero pad
  logic [2:0]  m_tuser;        // status, entry_valid
  logic        m_tlast;

  norm_sorted_keyed_table u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  table_cmd_t cmd_queue[$];
  table_cmd_t cur_cmd;
  entry_t     shadow_table[$];
  result_t    predicted_replies[$];

  int gap_left       = 0;
  int due_total      = 0;
  int rx_total       = 0;
  int rx_hold        = 0;
  bit long_hold_done = 1'b0;
  int mismatches     = 0;
  int cmds_sent      = 0;
  int peak_fill      = 0;
  int full_refusals  = 0;
  int dup_refusals   = 0;
  int lists_full     = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic longint sq_norm(logic signed [15:0] x, logic signed [15:0] y);
    return longint'(x) * longint'(x) + longint'(y) * longint'(y);
  endfunction

  function automatic void push_reply(status_t st, logic valid, entry_t e, logic lst);
    result_t r;
    r.status      = st;
    r.entry_valid = valid;
    r.entry       = valid ? e : '0;
    r.count       = COUNT_OUT_W'(shadow_table.size());
    r.last        = lst;
    predicted_replies.push_back(r);
    due_total++;
  endfunction

  // Shadow copy of the sorted table; queues the replies one command produces.
  function automatic void predict_reply(table_cmd_t c);
    int     pos;
    int     at;
    int     n;
    entry_t e;
    pos = -1;
    for (int i = 0; i < shadow_table.size(); i++) begin
      if (shadow_table[i].id == c.id) begin
        pos = i;
        break;
      end
    end
    e = '{tag: c.tag, y: c.y, x: c.x, id: c.id};
    case (c.cmd)
      CMD_ADD: begin
        if (pos >= 0) begin
          dup_refusals++;
          push_reply(STS_MISS, 1'b0, e, 1'b1);
        end else if (shadow_table.size() >= CAPACITY) begin
          full_refusals++;
          push_reply(STS_FULL, 1'b0, e, 1'b1);
        end else begin
          // strictly-less scan puts a new entry ahead of equal norms
          at = 0;
          while (at < shadow_table.size() &&
                 sq_norm(shadow_table[at].x, shadow_table[at].y) < sq_norm(e.x, e.y))
            at++;
          shadow_table.insert(at, e);
          if (shadow_table.size() > peak_fill) peak_fill = shadow_table.size();
          push_reply(STS_OK, 1'b0, e, 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (pos < 0) begin
          push_reply(STS_MISS, 1'b0, e, 1'b1);
        end else begin
          shadow_table.delete(pos);
          push_reply(STS_OK, 1'b0, e, 1'b1);
        end
      end
      CMD_CONTAINS: begin
        push_reply(pos >= 0 ? STS_OK : STS_MISS, 1'b0, e, 1'b1);
      end
      default: begin
        n = shadow_table.size();
        if (n > MAX_RESULTS) n = MAX_RESULTS;
        if (n == CAPACITY) lists_full++;
        if (n == 0) begin
          push_reply(STS_OK, 1'b0, e, 1'b1);
        end else begin
          for (int i = 0; i < n; i++)
            push_reply(STS_OK, 1'b1, shadow_table[i], i + 1 == n);
        end
      end
    endcase
  endfunction

  function automatic void queue_cmd(cmd_t c, logic [15:0] id, logic [15:0] x,
                                    logic [15:0] y, logic [15:0] tag, bit drain, bit gappy);
    table_cmd_t t;
    t.cmd   = c;
    t.id    = id;
    t.x     = x;
    t.y     = y;
    t.tag   = tag;
    t.drain = drain;
    t.gappy = gappy;
    cmd_queue.push_back(t);
  endfunction

  // Mix of full-range values, small multiples of 1.0 (norm ties) and extremes.
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 16'(($urandom_range(0, 4) * 256) - 512);
      1: begin
        case ($urandom_range(0, 2))
          0: return 16'h8000;
          1: return 16'h7FFF;
          default: return 16'h0000;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // Sender: one command in flight on the bus, random gap after each transfer of a gappy command.
  always @(posedge clk) begin : driver
    logic       fire;
    table_cmd_t nxt;
    fire = s_tvalid && s_tready;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (fire) begin
        predict_reply(cur_cmd);
        cmds_sent++;
      end
      if (!s_tvalid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (cmd_queue.size() > 0 &&
                     (!cmd_queue[0].drain || (!fire && due_total == rx_total))) begin
          nxt      = cmd_queue.pop_front();
          cur_cmd  = nxt;
          s_tdata  <= {nxt.tag, nxt.y, nxt.x, nxt.id};
          s_tuser  <= nxt.cmd;
          s_tvalid <= 1'b1;
          gap_left = nxt.gappy ? $urandom_range(0, 7) : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each reply transfer, stalls at random, one long hold-off.
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    int      stall;
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold  <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        rx_total <= rx_total + 1;
        got.status      = status_t'(m_tuser[1:0]);
        got.entry_valid = m_tuser[2];
        got.entry       = m_tdata[63:0];
        got.count       = m_tdata[68:64];
        got.last        = m_tlast;
        if (predicted_replies.size() == 0) begin
          $error("reply transfer with nothing pending: id %0d count %0d",
                 got.entry.id, got.count);
          mismatches++;
        end else begin
          want = predicted_replies.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
          end
          if (got.entry_valid !== want.entry_valid) begin
            $error("entry_valid: expected %0d, actual %0d", want.entry_valid, got.entry_valid);
            mismatches++;
          end
          if (got.entry.id !== want.entry.id) begin
            $error("out_id: expected %0d, actual %0d", want.entry.id, got.entry.id);
            mismatches++;
          end
          if (got.entry.x !== want.entry.x) begin
            $error("out_x: expected %0d, actual %0d", want.entry.x, got.entry.x);
            mismatches++;
          end
          if (got.entry.y !== want.entry.y) begin
            $error("out_y: expected %0d, actual %0d", want.entry.y, got.entry.y);
            mismatches++;
          end
          if (got.entry.tag !== want.entry.tag) begin
            $error("out_tag: expected %0d, actual %0d", want.entry.tag, got.entry.tag);
            mismatches++;
          end
          if (got.count !== want.count) begin
            $error("entry_count: expected %0d, actual %0d", want.count, got.count);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            mismatches++;
          end
        end
      end
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold  <= rx_hold - 1;
      end else if (!long_hold_done && rx_total >= 60) begin
        // back up the block while the sender keeps offering
        long_hold_done <= 1'b1;
        m_tready       <= 1'b0;
        rx_hold        <= LONG_HOLD - 1;
      end else if (m_tvalid && m_tready) begin
        stall = ((rx_total % 400) >= 300) ? 0 : $urandom_range(0, 7);
        if (stall > 0) begin
          m_tready <= 1'b0;
          rx_hold  <= stall - 1;
        end else begin
          m_tready <= 1'b1;
        end
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [15:0] id_pool[24];
    cmd_t        c;
    logic [15:0] id;
    int          r;
    bit          filling;

    // directed: empty table, extremes, norm ties, duplicate, full table
    queue_cmd(CMD_LIST,     16'd0,    16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);
    queue_cmd(CMD_REMOVE,   16'd5,    16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);
    queue_cmd(CMD_ADD,      16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 1'b0, 1'b1);
    queue_cmd(CMD_ADD,      16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);
    queue_cmd(CMD_ADD,      16'd1,    16'h0100, 16'h0000, 16'h1111, 1'b0, 1'b1);
    queue_cmd(CMD_ADD,      16'd2,    16'h0000, 16'h0100, 16'h2222, 1'b0, 1'b1);
    queue_cmd(CMD_ADD,      16'd3,    16'hFF00, 16'h0000, 16'h3333, 1'b0, 1'b1);
    queue_cmd(CMD_ADD,      16'd1,    16'h7FFF, 16'h7FFF, 16'h4444, 1'b0, 1'b1);
    queue_cmd(CMD_CONTAINS, 16'd2,    16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);
    queue_cmd(CMD_LIST,     16'd0,    16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);
    queue_cmd(CMD_REMOVE,   16'd2,    16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);
    for (int k = 0; k < CAPACITY - 4; k++)
      queue_cmd(CMD_ADD, 16'(100 + k), pick_coord(), pick_coord(), 16'($urandom), 1'b0, 1'b1);
    queue_cmd(CMD_ADD,      16'd500,  16'h0001, 16'h0001, 16'h5555, 1'b0, 1'b1);
    queue_cmd(CMD_ADD,      16'd100,  16'h0001, 16'h0001, 16'h6666, 1'b0, 1'b1);
    queue_cmd(CMD_LIST,     16'd0,    16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);

    for (int k = 0; k < 24; k++) id_pool[k] = 16'($urandom);
    id_pool[0] = 16'h8000;
    id_pool[1] = 16'h7FFF;
    id_pool[2] = 16'hFFFF;
    id_pool[3] = 16'h0000;

    // random: alternate fill and drain phases over a small id pool, some noise
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      filling = ((i / 60) % 2) == 0;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        queue_cmd(cmd_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 1'b0, 1'b1);
      end else begin
        r = $urandom_range(0, 99);
        if (filling)
          c = (r < 55) ? CMD_ADD : (r < 70) ? CMD_REMOVE : (r < 85) ? CMD_CONTAINS : CMD_LIST;
        else
          c = (r < 20) ? CMD_ADD : (r < 70) ? CMD_REMOVE : (r < 85) ? CMD_CONTAINS : CMD_LIST;
        id = id_pool[$urandom_range(0, 23)];
        queue_cmd(c, id, pick_coord(), pick_coord(), 16'($urandom),
                  (i % 97) == 96, !(i >= 250 && i < 330));
      end
    end

    @(negedge clk);
    while (rst || cmd_queue.size() != 0 || s_tvalid || due_total != rx_total)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("ran %0d commands, checked %0d reply transfers, peak fill %0d",
             cmds_sent, rx_total, peak_fill);
    $display("full-table refusals %0d, duplicate refusals %0d, full lists %0d",
             full_refusals, dup_refusals, lists_full);
    if (mismatches == 0 && predicted_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #(8 * 1000000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
